@@ src/dpr_pkg.sv @@
package dpr_pkg;

    // coordinate bits kept from column and row
    localparam int COORD_BITS = 12;
    localparam int COORD_W    = 12;
    localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((64'd1 << COORD_BITS) - 64'd1);

    localparam int DISP_W  = 16;
    localparam int CFG_W   = 32;
    localparam int PROD_W  = 48;
    localparam int NUM_W   = 34;
    localparam int UNUM_W  = 32;
    localparam int UDEN_W  = 47;
    localparam int OUT_W   = 48;

    // dividend is the numerator magnitude shifted up by the w fraction
    localparam int W_FRAC     = 28;
    localparam int DIV_STEPS  = UNUM_W + W_FRAC;
    localparam int OVF_STEPS  = DIV_STEPS - OUT_W;

    // front stages: multiply, w add, magnitudes; then divider steps and output stage
    localparam int FRONT_STAGES = 3;
    localparam int DIV_LAT      = DIV_STEPS + 1;
    localparam int PIPE_LAT     = FRONT_STAGES + DIV_LAT;

    localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [1:0]
    {
        STATUS_OK        = 2'd0,
        STATUS_ZERO_DISP = 2'd1,
        STATUS_ZERO_W    = 2'd2
    } status_t;

    typedef enum logic [2:0]
    {
        REG_X_OFFSET     = 3'd0,
        REG_Y_OFFSET     = 3'd1,
        REG_FOCAL_LENGTH = 3'd2,
        REG_INV_BASELINE = 3'd3,
        REG_DEPTH_OFFSET = 3'd4
    } cfg_index_t;

    typedef struct packed
    {
        logic               neg;
        logic [UNUM_W-1:0]  num_mag;
    } div_operand_t;

endpackage

@@ src/dpr_front.sv @@
module dpr_front
(
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [dpr_pkg::DISP_W-1:0] disparity,
    input  logic [dpr_pkg::COORD_W-1:0]       column,
    input  logic [dpr_pkg::COORD_W-1:0]       row,
    input  logic signed [dpr_pkg::CFG_W-1:0]  x_offset,
    input  logic signed [dpr_pkg::CFG_W-1:0]  y_offset,
    input  logic signed [dpr_pkg::CFG_W-1:0]  focal_length,
    input  logic signed [dpr_pkg::CFG_W-1:0]  inv_baseline,
    input  logic signed [dpr_pkg::CFG_W-1:0]  depth_offset,
    output dpr_pkg::div_operand_t             op_x,
    output dpr_pkg::div_operand_t             op_y,
    output dpr_pkg::div_operand_t             op_z,
    output logic [dpr_pkg::UDEN_W-1:0]        den_mag,
    output dpr_pkg::status_t                  status
);

    // stage 1: product and numerators
    logic signed [dpr_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [dpr_pkg::NUM_W-1:0]  numx_reg, numx_next;
    logic signed [dpr_pkg::NUM_W-1:0]  numy_reg, numy_next;
    logic signed [dpr_pkg::NUM_W-1:0]  numz_reg, numz_next;
    logic                              dzero1_reg;
    // stage 2: w
    logic signed [dpr_pkg::PROD_W-1:0] w_reg, w_next;
    logic signed [dpr_pkg::NUM_W-1:0]  numx2_reg, numy2_reg, numz2_reg;
    logic                              dzero2_reg;
    // stage 3: magnitudes
    dpr_pkg::div_operand_t             opx_reg, opy_reg, opz_reg;
    dpr_pkg::div_operand_t             opx_next, opy_next, opz_next;
    logic [dpr_pkg::UDEN_W-1:0]        den_reg, den_next;
    dpr_pkg::status_t                  status_reg, status_next;

    logic [dpr_pkg::COORD_W-1:0]       col_m;
    logic [dpr_pkg::COORD_W-1:0]       row_m;
    logic [dpr_pkg::PROD_W-1:0]        w_abs;

    function automatic dpr_pkg::div_operand_t make_op(logic signed [dpr_pkg::NUM_W-1:0] n,
                                                      logic w_neg, logic kill);
        dpr_pkg::div_operand_t o;
        logic [dpr_pkg::NUM_W-1:0] a;
        a = n[dpr_pkg::NUM_W-1] ? (~n + 1'b1) : n;
        o.num_mag = kill ? '0 : a[dpr_pkg::UNUM_W-1:0];
        o.neg     = n[dpr_pkg::NUM_W-1] ^ w_neg;
        return o;
    endfunction

    always_comb
    begin
        col_m     = column & dpr_pkg::COORD_MASK;
        row_m     = row & dpr_pkg::COORD_MASK;
        prod_next = dpr_pkg::PROD_W'(disparity) * dpr_pkg::PROD_W'(inv_baseline);
        numx_next = $signed({6'd0, col_m, 16'd0}) + dpr_pkg::NUM_W'(x_offset);
        numy_next = $signed({6'd0, row_m, 16'd0}) + dpr_pkg::NUM_W'(y_offset);
        numz_next = dpr_pkg::NUM_W'(focal_length);
    end

    always_comb
    begin
        w_next = prod_reg + (dpr_pkg::PROD_W'(depth_offset) <<< 4);
    end

    always_comb
    begin
        w_abs = w_reg[dpr_pkg::PROD_W-1] ? (~w_reg + 1'b1) : w_reg;
        if (dzero2_reg)
        begin
            status_next = dpr_pkg::STATUS_ZERO_DISP;
        end
        else if (w_reg == '0)
        begin
            status_next = dpr_pkg::STATUS_ZERO_W;
        end
        else
        begin
            status_next = dpr_pkg::STATUS_OK;
        end
        // special cases divide zero by one, giving a zero point
        den_next = (status_next != dpr_pkg::STATUS_OK) ? dpr_pkg::UDEN_W'(1)
                                                        : w_abs[dpr_pkg::UDEN_W-1:0];
        opx_next = make_op(numx2_reg, w_reg[dpr_pkg::PROD_W-1], status_next != dpr_pkg::STATUS_OK);
        opy_next = make_op(numy2_reg, w_reg[dpr_pkg::PROD_W-1], status_next != dpr_pkg::STATUS_OK);
        opz_next = make_op(numz2_reg, w_reg[dpr_pkg::PROD_W-1], status_next != dpr_pkg::STATUS_OK);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg   <= prod_next;
            numx_reg   <= numx_next;
            numy_reg   <= numy_next;
            numz_reg   <= numz_next;
            dzero1_reg <= (disparity == '0);
            w_reg      <= w_next;
            numx2_reg  <= numx_reg;
            numy2_reg  <= numy_reg;
            numz2_reg  <= numz_reg;
            dzero2_reg <= dzero1_reg;
            opx_reg    <= opx_next;
            opy_reg    <= opy_next;
            opz_reg    <= opz_next;
            den_reg    <= den_next;
            status_reg <= status_next;
        end
    end

    assign op_x    = opx_reg;
    assign op_y    = opy_reg;
    assign op_z    = opz_reg;
    assign den_mag = den_reg;
    assign status  = status_reg;

endmodule

@@ src/dpr_div.sv @@
module dpr_div
(
    input  logic                          clk,
    input  logic                          en,
    input  dpr_pkg::div_operand_t         op,
    input  logic [dpr_pkg::UDEN_W-1:0]    den_mag,
    output logic [dpr_pkg::OUT_W-1:0]     result
);

    localparam int N = dpr_pkg::DIV_STEPS;

    // one quotient bit per stage, restoring
    logic [dpr_pkg::UDEN_W-1:0] rem_reg [0:N-1];
    logic [dpr_pkg::UDEN_W-1:0] den_reg [0:N-1];
    logic [dpr_pkg::UNUM_W-1:0] num_reg [0:N-1];
    logic [dpr_pkg::OUT_W-1:0]  q_reg   [0:N-1];
    logic                       ovf_reg [0:N-1];
    logic                       neg_reg [0:N-1];
    logic [dpr_pkg::OUT_W-1:0]  result_reg, result_next;

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_step
            localparam int BIT = N - 1 - k;
            logic [dpr_pkg::UDEN_W-1:0] rem_in, den_in;
            logic [dpr_pkg::UNUM_W-1:0] num_in;
            logic [dpr_pkg::OUT_W-1:0]  q_in;
            logic                       ovf_in, neg_in, dbit, ge;
            logic [dpr_pkg::UDEN_W:0]   trial, diff;

            if (k == 0)
            begin : g_first
                assign rem_in = '0;
                assign den_in = den_mag;
                assign num_in = op.num_mag;
                assign q_in   = '0;
                assign ovf_in = 1'b0;
                assign neg_in = op.neg;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[k-1];
                assign den_in = den_reg[k-1];
                assign num_in = num_reg[k-1];
                assign q_in   = q_reg[k-1];
                assign ovf_in = ovf_reg[k-1];
                assign neg_in = neg_reg[k-1];
            end

            if (BIT >= dpr_pkg::W_FRAC)
            begin : g_dbit
                assign dbit = num_in[BIT - dpr_pkg::W_FRAC];
            end
            else
            begin : g_zbit
                assign dbit = 1'b0;
            end

            assign trial = {rem_in, dbit};
            assign diff  = trial - {1'b0, den_in};
            assign ge    = (trial >= {1'b0, den_in});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? diff[dpr_pkg::UDEN_W-1:0] : trial[dpr_pkg::UDEN_W-1:0];
                    den_reg[k] <= den_in;
                    num_reg[k] <= num_in;
                    neg_reg[k] <= neg_in;
                    if (k < dpr_pkg::OVF_STEPS)
                    begin
                        q_reg[k]   <= q_in;
                        ovf_reg[k] <= ovf_in | ge;
                    end
                    else
                    begin
                        q_reg[k]   <= {q_in[dpr_pkg::OUT_W-2:0], ge};
                        ovf_reg[k] <= ovf_in;
                    end
                end
            end
        end
    endgenerate

    // saturate and apply sign
    always_comb
    begin
        if (neg_reg[N-1])
        begin
            if (ovf_reg[N-1] || (q_reg[N-1][dpr_pkg::OUT_W-1] && (q_reg[N-1][dpr_pkg::OUT_W-2:0] != '0)))
            begin
                result_next = dpr_pkg::SAT_NEG;
            end
            else
            begin
                result_next = ~q_reg[N-1] + 1'b1;
            end
        end
        else
        begin
            if (ovf_reg[N-1] || q_reg[N-1][dpr_pkg::OUT_W-1])
            begin
                result_next = dpr_pkg::SAT_POS;
            end
            else
            begin
                result_next = q_reg[N-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

@@ src/disparity_to_point_reprojection.sv @@
// Disparity to 3D point reprojection. Each input word carries a signed disparity (4
// fractional bits) with its pixel column and row; each output word carries the point
// X, Y, Z (signed, 16 fractional bits, saturated to 48 bits) and a status on tuser
// (0 valid, 1 zero disparity, 2 zero weight, in which cases the point is zero). The
// block takes one word per clock unless the output stalls, and is fully pipelined:
// three front stages (16x32 multiply, weight add, magnitudes) followed by three parallel
// 60-step restoring dividers, one quotient bit per stage, and a saturating output
// register. Backpressure on the output stalls the whole pipeline in place. The five
// calibration registers are written through the cfg port and should only change while
// no words are in flight.
module disparity_to_point_reprojection
(
    input  logic         clk,
    input  logic         rst_n,
    // calibration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,    // disparity[15:0], column[27:16], row[39:28]
    // output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,    // point_x[47:0], point_y[95:48], point_z[143:96]
    output logic [1:0]   m_tuser     // status[1:0]
);

    localparam int LAT = dpr_pkg::PIPE_LAT;

    logic signed [31:0] x_offset_reg;
    logic signed [31:0] y_offset_reg;
    logic signed [31:0] focal_length_reg;
    logic signed [31:0] inv_baseline_reg;
    logic signed [31:0] depth_offset_reg;

    logic                              en;
    logic [LAT-1:0]                    vld_reg, vld_next;
    dpr_pkg::status_t                  status_pipe_reg [0:dpr_pkg::DIV_LAT-1];

    dpr_pkg::div_operand_t             op_x, op_y, op_z;
    logic [dpr_pkg::UDEN_W-1:0]        den_mag;
    dpr_pkg::status_t                  front_status;
    logic [dpr_pkg::OUT_W-1:0]         point_x, point_y, point_z;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_offset_reg     <= '0;
            y_offset_reg     <= '0;
            focal_length_reg <= '0;
            inv_baseline_reg <= '0;
            depth_offset_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dpr_pkg::REG_X_OFFSET:     x_offset_reg     <= cfg_data;
                dpr_pkg::REG_Y_OFFSET:     y_offset_reg     <= cfg_data;
                dpr_pkg::REG_FOCAL_LENGTH: focal_length_reg <= cfg_data;
                dpr_pkg::REG_INV_BASELINE: inv_baseline_reg <= cfg_data;
                dpr_pkg::REG_DEPTH_OFFSET: depth_offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipeline advances unless a finished word is held at the output
    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;

    always_comb
    begin
        vld_next = {vld_reg[LAT-2:0], s_tvalid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    dpr_front u_front
    (
        .clk          (clk),
        .en           (en),
        .disparity    (s_tdata[15:0]),
        .column       (s_tdata[27:16]),
        .row          (s_tdata[39:28]),
        .x_offset     (x_offset_reg),
        .y_offset     (y_offset_reg),
        .focal_length (focal_length_reg),
        .inv_baseline (inv_baseline_reg),
        .depth_offset (depth_offset_reg),
        .op_x         (op_x),
        .op_y         (op_y),
        .op_z         (op_z),
        .den_mag      (den_mag),
        .status       (front_status)
    );

    dpr_div u_div_x (.clk(clk), .en(en), .op(op_x), .den_mag(den_mag), .result(point_x));
    dpr_div u_div_y (.clk(clk), .en(en), .op(op_y), .den_mag(den_mag), .result(point_y));
    dpr_div u_div_z (.clk(clk), .en(en), .op(op_z), .den_mag(den_mag), .result(point_z));

    // status rides alongside the dividers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            status_pipe_reg[0] <= front_status;
            for (int i = 1; i < dpr_pkg::DIV_LAT; i++)
            begin
                status_pipe_reg[i] <= status_pipe_reg[i-1];
            end
        end
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = {point_z, point_y, point_x};
    assign m_tuser  = status_pipe_reg[dpr_pkg::DIV_LAT-1];

    // special-case words carry a zero point
    a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != dpr_pkg::STATUS_OK) |-> (m_tdata == '0))
        else $error("special case word with nonzero point");

    // status code 3 is never produced
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser != 2'd3))
        else $error("undefined status code");

    // input is held off only by a stalled output word
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

endmodule
